@@ rtl/b2d_pkg.sv @@
// shared types and constants for the binary to decimal ascii converter
package b2d_pkg;

    localparam int VALUE_W = 32;
    localparam int CHAR_W  = 6;
    localparam int DIG_W   = 4;

    // a 32-bit value never has more than this many decimal digits
    localparam int DEC_SPAN = 10;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    // floor(v * RECIP_10 / 2**RECIP_SHIFT) == v / 10 for every 32-bit v
    localparam logic [VALUE_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int                 RECIP_SHIFT = 35;

    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [CHAR_W-1:0]  t_char;
    typedef logic [DIG_W-1:0]   t_digit;

endpackage

@@ rtl/b2d_if.sv @@
// valid/ready channel interfaces for the input values and the output characters
interface b2d_in_if;
    import b2d_pkg::*;

    logic   valid;
    logic   ready;
    t_value value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface b2d_out_if;
    import b2d_pkg::*;

    logic  valid;
    logic  ready;
    t_char digit_char;
    logic  last;

    modport source (output valid, output digit_char, output last, input ready);
    modport sink   (input valid, input digit_char, input last, output ready);
endinterface

@@ rtl/b2d_div10.sv @@
// shared divide-by-ten unit: reciprocal multiply for the quotient, low-bit remainder
module b2d_div10 (
    input  b2d_pkg::t_value i_val,
    input  b2d_pkg::t_digit i_prev_lo,
    output b2d_pkg::t_value o_quot,
    output b2d_pkg::t_digit o_rem
);
    import b2d_pkg::*;

    logic [2*VALUE_W-1:0] prod;
    t_digit               ten_q_lo;

    assign prod   = {{VALUE_W{1'b0}}, i_val} * {{VALUE_W{1'b0}}, RECIP_10};
    assign o_quot = t_value'(prod >> RECIP_SHIFT);

    // i_val is the quotient of the previous value, so prev - 10*i_val is its remainder;
    // the remainder is below ten, so four bits of the difference are enough
    assign ten_q_lo = {i_val[0], 3'b000} + {i_val[2:0], 1'b0};
    assign o_rem    = i_prev_lo - ten_q_lo;
endmodule

@@ rtl/binary_to_decimal_ascii.sv @@
// converts an n-digit value: accepts it, peels its digits through one divide unit least significant first,
// then emits characters most significant first, one per cycle while the output is not stalled
// a new value is taken only once the last character of the previous one is loaded for output,
// since the divide-by-ten multiplier and the single digit buffer serve one value at a time
// synchronous active-low reset clears the sequencer and output valid; no clearing pass
module binary_to_decimal_ascii #(
    parameter int MAX_DIGITS = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    b2d_in_if.sink           i_in,
    b2d_out_if.source        o_out
);
    import b2d_pkg::*;

    localparam int DEPTH = (MAX_DIGITS < DEC_SPAN) ? MAX_DIGITS : DEC_SPAN;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_PEEL = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state           r_state, n_state;
    t_value           r_val, n_val;
    t_digit           r_prev, n_prev;
    logic             r_pend, n_pend;
    logic [IDX_W-1:0] r_cnt, n_cnt;
    logic [IDX_W-1:0] r_rd, n_rd;
    t_digit           r_dig [DEPTH];
    logic             r_ovalid, n_ovalid;
    t_char            r_ochar, n_ochar;
    logic             r_olast, n_olast;

    logic             dig_we;
    logic             out_free;
    t_value           quot;
    t_digit           rem;

    b2d_div10 u_div10 (
        .i_val     (r_val),
        .i_prev_lo (r_prev),
        .o_quot    (quot),
        .o_rem     (rem)
    );

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_ovalid;
    assign o_out.digit_char = r_ochar;
    assign o_out.last       = r_olast;

    assign out_free = !r_ovalid || o_out.ready;

    always_comb begin
        n_state  = r_state;
        n_val    = r_val;
        n_prev   = r_prev;
        n_pend   = r_pend;
        n_cnt    = r_cnt;
        n_rd     = r_rd;
        n_ovalid = r_ovalid;
        n_ochar  = r_ochar;
        n_olast  = r_olast;
        dig_we   = 1'b0;

        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_val   = i_in.value;
                    n_pend  = 1'b0;
                    n_cnt   = '0;
                    n_state = S_PEEL;
                end
            end
            S_PEEL: begin
                // the remainder of r_prev is formed in the cycle after its quotient, from the registered quotient
                n_prev = r_val[DIG_W-1:0];
                n_val  = quot;
                n_pend = 1'b1;
                if (r_pend) begin
                    dig_we = 1'b1;
                    if (r_val == '0 || r_cnt == IDX_W'(DEPTH - 1)) begin
                        n_rd    = r_cnt;
                        n_state = S_EMIT;
                    end else begin
                        n_cnt = r_cnt + 1'b1;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_ochar  = ASCII_ZERO + {{(CHAR_W - DIG_W){1'b0}}, r_dig[r_rd]};
                    n_olast  = (r_rd == '0);
                    if (r_rd == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_rd = r_rd - 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val   <= n_val;
        r_prev  <= n_prev;
        r_pend  <= n_pend;
        r_cnt   <= n_cnt;
        r_rd    <= n_rd;
        r_ochar <= n_ochar;
        r_olast <= n_olast;
        if (dig_we) begin
            r_dig[r_cnt] <= rem;
        end
    end
endmodule

@@ rtl/b2d_chk.sv @@
// port-level assertions for the converter and their bind to the top level
module b2d_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input b2d_pkg::t_char      i_out_char,
    input logic                i_out_last
);
    import b2d_pkg::*;

    // a stalled output transaction keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_char) && $stable(i_out_last))
        else $error("output transaction changed while stalled");

    // ready stays low right after an input transaction, while its first digit is being peeled
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready ##1 !i_in_ready)
        else $error("input taken again too early");

    // when ready returns, the final digit of a run is loaded in the output
    a_ready_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_in_ready) |-> i_out_valid && i_out_last)
        else $error("ready returned without final digit");

    // a run has no gap once its first digit is out
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_out_last |=> i_out_valid)
        else $error("gap inside a digit run");
endmodule

bind binary_to_decimal_ascii b2d_chk u_b2d_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_char  (o_out.digit_char),
    .i_out_last  (o_out.last)
);
